FILE: design/rgb_colour_fader_top_assert.svh
// ----------------------------------------------------------------------------
// rgb colour fader assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RGB_COLOUR_FADER_TOP_ASSERT_SVH
`define RGB_COLOUR_FADER_TOP_ASSERT_SVH

// same-cycle implication
`define RCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// shared types, constants and the channel interpolation function
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam int POS_W = 18;
	localparam int RATE_W = 17;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [POS_W-1:0] ONE_Q16 = 18'd65536;
	localparam logic [4:0] DIV_STEPS = 5'd17;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_START = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FADE_IN = 2'd1,
		PH_HOLD = 2'd2,
		PH_FADE_OUT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		BS_IDLE = 2'd0,
		BS_DIV = 2'd1,
		BS_EMIT = 2'd2
	} bstate_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		cmd_t cmd;
		rgb_t target;
		logic [7:0] step_count;
		rgb_t base;
	} item_t;

	// from + t * (to - from), t in unsigned q1.16, truncated
	function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
			input logic [16:0] t);
		logic signed [8:0] diff;
		logic signed [17:0] ts;
		logic signed [26:0] prod;
		logic signed [26:0] v;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		ts = $signed({1'b0, t});
		prod = ts * diff;
		v = $signed({3'b000, a, 16'h0000}) + prod;
		if (v < 0) begin
			return 8'd0;
		end
		return v[23:16];
	endfunction

endpackage

FILE: design/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front
// input stage: takes a beat, decodes the command and hands it to the queue
// ----------------------------------------------------------------------------
module rcf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  rcf_pkg::rgb_t target,
	input  logic [7:0]    step_count,
	input  rcf_pkg::rgb_t base,
	output logic          push,
	output rcf_pkg::item_t push_item,
	input  logic          push_ready
);
	import rcf_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	cmd_t  cmd;
	logic  accept;

	// every func value has a command of the same encoding
	assign cmd = cmd_t'(func);

	assign in_ready = !valid_s1 || push_ready;
	assign accept = in_valid && in_ready;
	assign push = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd <= cmd;
			item_s1.target <= target;
			item_s1.step_count <= step_count;
			item_s1.base <= base;
		end
	end

endmodule

FILE: design/rcf_queue.sv
// ----------------------------------------------------------------------------
// rcf_queue
// small fifo of decoded commands between the front and back ends
// ----------------------------------------------------------------------------
`include "rgb_colour_fader_top_assert.svh"

module rcf_queue #(
	parameter int DEPTH = rcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rcf_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output rcf_pkg::item_t head,
	output logic           not_empty
);
	import rcf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && push_ready;
	assign do_pop = pop && not_empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`RCF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`RCF_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")
	`RCF_ASSERT_NEXT(a_count_dn, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

FILE: design/rcf_divider.sv
// ----------------------------------------------------------------------------
// rcf_divider
// restoring divider (a step count of 0 is taken as 1), one quotient bit per cycle: rate = 65536 / step count
// ----------------------------------------------------------------------------
module rcf_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [7:0]                 step_count,
	output logic                       done,
	output logic [rcf_pkg::RATE_W-1:0] rate
);
	import rcf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [7:0]        dvs_q;
	logic [7:0]        rem_q;
	logic [RATE_W-1:0] quo_q;
	logic [8:0]        trial;
	logic              ge;
	logic [8:0]        rem_n;

	// dividend is 1.0 in q1.16: only its top bit is set
	assign trial = {rem_q, (cnt_q == DIV_STEPS)};
	assign ge = (trial >= {1'b0, dvs_q});
	assign rem_n = ge ? (trial - {1'b0, dvs_q}) : trial;
	assign done = done_q;
	assign rate = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= (step_count == 8'd0) ? 8'd1 : step_count;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n[7:0];
			quo_q <= {quo_q[RATE_W-2:0], ge};
		end
	end

endmodule

FILE: design/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back
// executes commands: fade state, interpolation and the output register
// ----------------------------------------------------------------------------
`include "rgb_colour_fader_top_assert.svh"

module rcf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rcf_pkg::item_t head,
	input  logic           not_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output rcf_pkg::rgb_t  out_colour,
	output logic           fade_busy,
	output logic [1:0]     fade_phase
);
	import rcf_pkg::*;

	bstate_t           state_q;
	bstate_t           state_n;
	item_t             item_q;
	phase_t            phase_q;
	phase_t            phase_n;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_n;
	logic [POS_W-1:0]  pos_sum;
	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] rate_n;
	rgb_t              from_q;
	rgb_t              from_n;
	rgb_t              to_q;
	rgb_t              to_n;
	rgb_t              cur_q;
	rgb_t              cur_n;
	rgb_t              lerp_c;
	logic              busy_n;
	logic              out_valid_q;
	rgb_t              out_colour_q;
	logic              fade_busy_q;
	phase_t            fade_phase_q;
	logic              out_free;
	logic              emit;
	logic              div_start;
	logic              div_done;
	logic [RATE_W-1:0] div_rate;
	logic              is_div_cmd;
	logic              out_fading;

	rcf_divider u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.step_count (head.step_count),
		.done       (div_done),
		.rate       (div_rate)
	);

	assign out_free = !out_valid_q || out_ready;
	assign is_div_cmd = (head.cmd == CMD_START) || (head.cmd == CMD_RELEASE);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BS_IDLE: begin
				if (not_empty) begin
					state_n = is_div_cmd ? BS_DIV : BS_EMIT;
				end
			end
			BS_DIV: begin
				if (div_done) begin
					state_n = BS_EMIT;
				end
			end
			BS_EMIT: begin
				if (out_free) begin
					state_n = BS_IDLE;
				end
			end
			default: state_n = BS_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		emit = 1'b0;
		case (state_q)
			BS_IDLE: begin
				pop = not_empty;
				div_start = not_empty && is_div_cmd;
			end
			BS_EMIT: emit = out_free;
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign lerp_c.r = lerp(from_q.r, to_q.r, pos_q[16:0]);
	assign lerp_c.g = lerp(from_q.g, to_q.g, pos_q[16:0]);
	assign lerp_c.b = lerp(from_q.b, to_q.b, pos_q[16:0]);
	assign pos_sum = pos_q + POS_W'(rate_q);

	// command execution
	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		rate_n = rate_q;
		from_n = from_q;
		to_n = to_q;
		cur_n = cur_q;
		busy_n = 1'b0;
		case (item_q.cmd)
			CMD_START: begin
				rate_n = div_rate;
				pos_n = '0;
				if (phase_q == PH_IDLE) begin
					from_n = item_q.base;
					cur_n = item_q.base;
				end
				to_n = item_q.target;
				phase_n = PH_FADE_IN;
			end
			CMD_TICK: begin
				if ((phase_q == PH_FADE_IN || phase_q == PH_FADE_OUT) && pos_q <= ONE_Q16) begin
					cur_n = lerp_c;
					pos_n = pos_sum;
					busy_n = 1'b1;
					if (pos_sum > ONE_Q16) begin
						busy_n = 1'b0;
						phase_n = (phase_q == PH_FADE_IN) ? PH_HOLD : PH_IDLE;
					end
				end
			end
			CMD_RELEASE: begin
				if (phase_q != PH_IDLE) begin
					rate_n = div_rate;
					pos_n = '0;
					to_n = item_q.base;
					from_n = cur_q;
					phase_n = PH_FADE_OUT;
				end
			end
			default: begin
				busy_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			phase_q <= PH_IDLE;
			pos_q <= '0;
			rate_q <= '0;
			from_q <= '0;
			to_q <= '0;
			cur_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit) begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				rate_q <= rate_n;
				from_q <= from_n;
				to_q <= to_n;
				cur_q <= cur_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		if (emit) begin
			out_colour_q <= (phase_n != PH_IDLE) ? cur_n : item_q.base;
			fade_busy_q <= busy_n;
			fade_phase_q <= phase_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_colour = out_colour_q;
	assign fade_busy = fade_busy_q;
	assign fade_phase = fade_phase_q;
	assign out_fading = (fade_phase_q == PH_FADE_IN) || (fade_phase_q == PH_FADE_OUT);

	`RCF_ASSERT_NOW(a_div_done_state, div_done, state_q == BS_DIV, "divider done outside wait")
	`RCF_ASSERT_NOW(a_pop_idle, pop, state_q == BS_IDLE && not_empty, "pop outside idle")
	`RCF_ASSERT_NOW(a_busy_fading, out_valid_q && fade_busy_q, out_fading, "busy while not fading")

endmodule

FILE: design/rgb_colour_fader_top.sv
// a tick beat passes the input register, the queue and the back end's idle and
// emit states to the output; a start or release beat also waits in the divide
// state while the 17-step rate divider runs. The back end works one command at a
// time and pops no new command from the queue until the last one is emitted
// reset: arst_n clears the fade state to idle with zero colours and empties the queue
// ----------------------------------------------------------------------------
// rgb_colour_fader_top
// linear rgb fader: input stage, command queue and fade execution back end
// ----------------------------------------------------------------------------
module rgb_colour_fader_top #(
	parameter int QUEUE_DEPTH = rcf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] target_red,
	input  logic [7:0] target_green,
	input  logic [7:0] target_blue,
	input  logic [7:0] step_count,
	input  logic [7:0] base_red,
	input  logic [7:0] base_green,
	input  logic [7:0] base_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       fade_busy,
	output logic [1:0] fade_phase
);
	import rcf_pkg::*;

	rgb_t  target;
	rgb_t  base;
	rgb_t  out_colour;
	logic  push;
	item_t push_item;
	logic  push_ready;
	logic  pop;
	item_t head;
	logic  not_empty;

	assign target = '{r: target_red, g: target_green, b: target_blue};
	assign base = '{r: base_red, g: base_green, b: base_blue};

	rcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.target     (target),
		.step_count (step_count),
		.base       (base),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	rcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	rcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.not_empty  (not_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_colour (out_colour),
		.fade_busy  (fade_busy),
		.fade_phase (fade_phase)
	);

	assign out_red = out_colour.r;
	assign out_green = out_colour.g;
	assign out_blue = out_colour.b;

endmodule
